>>> rtl/bdat_pkg.sv
package bdat_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned NUM_W      = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [OP_W-1:0] {
    OP_BIND  = 2'd0,
    OP_ALARM = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [NUM_W-1:0]  number;
    logic [ADDR_W-1:0] address;
  } entry_t;

endpackage

>>> rtl/bound_device_alarm_table.sv
// Channel | Ports                        | Contents
// in      | in_tvalid/in_tready          | tuser: operation; tdata: address, device_number,
//         |                              |   timestamp
// out     | out_tvalid/out_tready        | tuser: pending_found; tdata: status,
//         |                              |   pending_address, pending_number, pending_time,
//         |                              |   bound_count
// One request at a time: accept, address search (skipped for a bind to a full
// table and for unknown operations), flag scan, then load the output register.
// The single-port entry memory (registered read) sets the pace of the address
// search. Synchronous active-low reset empties the table at once (count and
// flags are flops). A stalled output holds the next request in FINISH.
module bound_device_alarm_table
  import bdat_pkg::*;
#(
  parameter int unsigned MAX_DEVICES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] operation
  input  logic [OP_W-1:0]       in_tuser,
  // [31:0] address, [39:32] device_number, [71:40] timestamp
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] pending_found
  output logic [0:0]            out_tuser,
  // [0] status, [32:1] pending_address, [40:33] pending_number,
  // [72:41] pending_time, [77:73] bound_count, [79:78] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DEVICES + 1);

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic              status_r, status_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [MAX_DEVICES-1:0] flag_r, flag_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  o_found_r, o_found_nxt;
  logic [OUT_DATA_W-1:0] o_data_r, o_data_nxt;

  entry_t           mem [MAX_DEVICES];
  entry_t           rd_data_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  entry_t           mem_wd;

  logic accept, full, hit, walk_left, search_end, out_free;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign full       = (count_r >= CNT_W'(MAX_DEVICES));
  assign hit        = cmp_v_r && (rd_data_r.address == addr_r);
  assign walk_left  = (idx_r < count_r);
  assign search_end = hit || (!walk_left && !cmp_v_r);
  assign out_free   = !out_valid_r || out_tready;
  assign count_ext  = {{COUNT_W{1'b0}}, count_r};

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_found_r;
  assign out_tdata  = o_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_tuser)) inside
            OP_BIND:           state_nxt = full ? ST_SCAN : ST_SEARCH;
            OP_ALARM, OP_CLEAR: state_nxt = ST_SEARCH;
            default:           state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_SEARCH: if (search_end) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (!walk_left || flag_r[idx_r[IDX_W-1:0]]) state_nxt = ST_FINISH;
      end
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    num_nxt       = num_r;
    time_nxt      = time_r;
    status_nxt    = status_r;
    pend_nxt      = pend_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_idx_nxt   = cmp_idx_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_found_nxt   = o_found_r;
    o_data_nxt    = o_data_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = idx_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_tuser;
          addr_nxt   = in_tdata[31:0];
          num_nxt    = in_tdata[39:32];
          time_nxt   = in_tdata[71:40];
          status_nxt = (op_t'(in_tuser) == OP_BIND) && full;
          idx_nxt    = '0;
          cmp_v_nxt  = 1'b0;
          pend_nxt   = 1'b0;
        end
      end
      ST_SEARCH: begin
        if (search_end) begin
          idx_nxt   = '0;
          cmp_v_nxt = 1'b0;
          case (op_t'(op_r))
            OP_BIND: begin
              if (!hit) begin
                mem_we   = 1'b1;
                mem_wa   = count_r[IDX_W-1:0];
                mem_wd   = '{stamp: '0, number: num_r, address: addr_r};
                flag_nxt[count_r[IDX_W-1:0]] = 1'b0;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_ALARM: begin
              if (hit) begin
                mem_we   = 1'b1;
                mem_wa   = cmp_idx_r;
                mem_wd   = '{stamp: time_r, number: rd_data_r.number, address: addr_r};
                flag_nxt[cmp_idx_r] = 1'b1;
              end
            end
            OP_CLEAR: if (hit) flag_nxt[cmp_idx_r] = 1'b0;
            default: ;
          endcase
        end else if (walk_left) begin
          // keep one read in flight, compare it the next cycle
          mem_re      = 1'b1;
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt     = idx_r + CNT_W'(1);
        end else begin
          cmp_v_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (walk_left) begin
          if (flag_r[idx_r[IDX_W-1:0]]) begin
            mem_re   = 1'b1;
            pend_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          o_found_nxt        = pend_r;
          o_data_nxt         = '0;
          o_data_nxt[0]      = status_r;
          if (pend_r) begin
            o_data_nxt[32:1]  = rd_data_r.address;
            o_data_nxt[40:33] = rd_data_r.number;
            o_data_nxt[72:41] = rd_data_r.stamp;
          end
          o_data_nxt[77:73]  = count_ext[COUNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      flag_r      <= '0;
      idx_r       <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      flag_r      <= flag_nxt;
      idx_r       <= idx_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    addr_r    <= addr_nxt;
    num_r     <= num_nxt;
    time_r    <= time_nxt;
    status_r  <= status_nxt;
    pend_r    <= pend_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    o_found_r <= o_found_nxt;
    o_data_r  <= o_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

endmodule
